### rtl/epl_pkg.sv
// Shared types and constants for the encoder position limiter.
package epl_pkg;

  localparam int LED_COUNT_DEF = 16;
  localparam int SCALE_MAX     = 9;
  localparam int POS_W         = 15;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;

  localparam logic [POS_W-1:0] TOP_CAP = 15'd32764;

  typedef logic [1:0] stop_t;
  localparam stop_t STOP_NONE   = 2'd0;
  localparam stop_t STOP_TOP    = 2'd1;
  localparam stop_t STOP_BOTTOM = 2'd2;

  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SCALE  = 2'd1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    stop_t            stop;
  } epl_state_t;

  typedef struct packed {
    logic        draw_valid;
    logic [3:0]  led_index;
    logic        counter_write;
    logic [14:0] counter_load;
    logic [12:0] detent_position;
  } epl_result_t;

endpackage

### rtl/epl_step.sv
// Per-item update of position and stop state, with the result fields.
module epl_step #(
  parameter int LED_COUNT = epl_pkg::LED_COUNT_DEF
) (
  input  logic                 func,
  input  logic [15:0]          counter_value,
  input  logic                 counting_down,
  input  logic                 limit_enable,
  input  logic [3:0]           range_scale,
  input  epl_pkg::epl_state_t  state,
  output epl_pkg::epl_state_t  state_next,
  output epl_pkg::epl_result_t result
);
  import epl_pkg::*;

  // wide enough for LED_COUNT shifted by the largest scale
  localparam int TW = $clog2(LED_COUNT + 1) + 2 + SCALE_MAX;
  localparam int CW = (TW > 16) ? TW : 16;

  logic [CW-1:0]    full;
  logic [CW-1:0]    top_raw;
  logic [POS_W-1:0] top;
  logic [4:0]       shamt;
  logic [POS_W-1:0] pos_shift;
  logic             draw;
  logic             wr;
  logic [POS_W-1:0] load;

  assign shamt   = 5'(range_scale) + 5'd2;
  assign full    = CW'(LED_COUNT) << shamt;
  assign top_raw = full - CW'(4);
  assign top     = (top_raw > CW'(TOP_CAP)) ? TOP_CAP : top_raw[POS_W-1:0];

  always_comb begin
    state_next = state;
    draw       = 1'b0;
    wr         = 1'b0;
    load       = '0;
    if (func == FUNC_RESTART) begin
      state_next.position = '0;
      draw = 1'b1;
      wr   = 1'b1;
    end else if (counter_value == {1'b0, state.position} || counter_value[1:0] != 2'd0) begin
      // ignored sample
    end else if (limit_enable && state.stop == STOP_BOTTOM) begin
      if (!counting_down) begin
        state_next.stop     = STOP_NONE;
        state_next.position = '0;
        draw = 1'b1;
        wr   = 1'b1;
      end
    end else if (limit_enable && state.stop == STOP_TOP) begin
      if (counting_down) begin
        state_next.stop     = STOP_NONE;
        state_next.position = top;
        draw = 1'b1;
        wr   = 1'b1;
        load = top;
      end
    end else if (counter_value > {1'b0, top}) begin
      draw = 1'b1;
      if (limit_enable && state.stop == STOP_NONE) begin
        state_next.position = counting_down ? '0 : top;
        state_next.stop     = counting_down ? STOP_BOTTOM : STOP_TOP;
      end else begin
        state_next.position = counting_down ? top : '0;
        wr   = 1'b1;
        load = counting_down ? top : '0;
      end
    end else begin
      state_next.position = counter_value[POS_W-1:0];
      draw = 1'b1;
    end
  end

  assign pos_shift = state_next.position >> shamt;

  always_comb begin
    result.draw_valid      = draw;
    result.led_index       = draw ? pos_shift[3:0] : 4'd0;
    result.counter_write   = wr;
    result.counter_load    = load;
    result.detent_position = state_next.position[POS_W-1:2];
  end

endmodule

### rtl/encoder_position_limiter.sv
// Encoder position limiter top level: input register, update logic, result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per accepted edge, either a
//   counter sample (func = 0) with its count-down flag, or a restart (func = 1).
//   Output channel (out_valid / out_stall): exactly one result item per input
//   item, in order: draw flag and LED index, counter write-back flag and value,
//   and the stored position in detents.
//   Config channel (cfg_valid / cfg_ready): index 0 limit_enable, index 1
//   range_scale (values above 9 store 9); other indexes are dropped. cfg_ready
//   is always high. Write only while no item is in flight, then send a restart.
// Timing:
//   An item accepted into the input register moves on into the result register
//   once that register is free. One item per cycle is sustained while out_stall
//   is low; the position update is a single compare/select pass.
// Reset (rst, synchronous): clears position, stop state, config and both
//   valid flags.
// Stall: a stalled result holds; the input register still takes one item, and
//   in_stall rises only while the input register is full and the result stalls.
module encoder_position_limiter #(
  parameter int LED_COUNT = epl_pkg::LED_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [15:0]                     counter_value,
  input  logic                            counting_down,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            draw_valid,
  output logic [3:0]                      led_index,
  output logic                            counter_write,
  output logic [14:0]                     counter_load,
  output logic [12:0]                     detent_position,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [epl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import epl_pkg::*;

  // config registers
  logic       limit_enable;
  logic [3:0] range_scale;

  // input register
  logic        in_full;
  logic        s1_func;
  logic [15:0] s1_value;
  logic        s1_down;

  // knob state, committed as an item moves into the result register
  epl_state_t  state;
  epl_state_t  state_next;

  epl_result_t res;
  epl_result_t res_next;

  logic in_accept;
  logic advance;

  assign cfg_ready = 1'b1;

  // result register frees up when empty or being taken this cycle
  assign advance   = in_full && !(out_valid && out_stall);
  assign in_stall  = in_full && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      range_scale  <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        CFG_RANGE_SCALE: begin
          range_scale <= (cfg_data > CFG_DATA_W'(SCALE_MAX)) ? 4'(SCALE_MAX)
                                                            : cfg_data[3:0];
        end
        default: ;
      endcase
    end
  end

  epl_step #(
    .LED_COUNT(LED_COUNT)
  ) u_step (
    .func          (s1_func),
    .counter_value (s1_value),
    .counting_down (s1_down),
    .limit_enable  (limit_enable),
    .range_scale   (range_scale),
    .state         (state),
    .state_next    (state_next),
    .result        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_valid      <= 1'b0;
      state.position <= '0;
      state.stop     <= STOP_NONE;
    end else begin
      in_full <= in_accept || (in_full && !advance);
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func  <= func;
      s1_value <= counter_value;
      s1_down  <= counting_down;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign draw_valid      = res.draw_valid;
  assign led_index       = res.led_index;
  assign counter_write   = res.counter_write;
  assign counter_load    = res.counter_load;
  assign detent_position = res.detent_position;

  // the block never creates the unused stop code
  a_stop_code: assert property (@(posedge clk) disable iff (rst)
    state.stop != 2'd3)
    else $error("stop state holds the unused code");

  // position always sits on a detent boundary
  a_pos_aligned: assert property (@(posedge clk) disable iff (rst)
    state.position[1:0] == 2'd0)
    else $error("position not a multiple of four");

  a_scale_sat: assert property (@(posedge clk) disable iff (rst)
    range_scale <= 4'(SCALE_MAX))
    else $error("range_scale above saturation");

  // write-back value and LED index are zero when their flags are clear
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((counter_write || counter_load == '0) &&
                   (draw_valid || led_index == '0)))
    else $error("result field set without its flag");

  // a new result only appears when the input register held an item
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_full))
    else $error("result without a pending item");

endmodule
